[hdl/first_fit_region_allocator_top_defines.svh]
// assertion macros for the first-fit region allocator
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, checked outside reset
`define FFRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

[hdl/ffra_pkg.sv]
// shared types, codes and helpers of the first-fit region allocator
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int MAX_REGIONS_DEF = 32;
  localparam logic [31:0] POOL_START_RST = 32'h0010_0000;
  localparam logic [31:0] POOL_BYTES_RST = 32'h0010_0000;
  localparam logic [31:0] MIN_BLOCK_RST  = 32'd32;
  localparam logic [31:0] TOP_LIMIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] ROUND_MAX      = 32'hFFFF_FFE0;
  localparam logic [31:0] ROUND_ADD      = 32'd31;
  localparam logic [31:0] ROUND_MASK     = ~32'd31;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_REINIT = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [1:0] CFG_POOL_START = 2'd0;
  localparam logic [1:0] CFG_POOL_BYTES = 2'd1;
  localparam logic [1:0] CFG_MIN_BLOCK  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] region_base;
    logic [31:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] grant_address;
    logic [1:0]  status;
    logic [31:0] free_bytes;
    logic [5:0]  region_count;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_SHIFT_DN,
    OP_SHIFT_UP
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] wbase;
    logic [31:0] wsize;
    logic        tok_load;
    logic        tok_adv;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ASCAN,
    ST_FSCAN,
    ST_FDROP
  } state_t;

  // length clipped so the region ends below the top byte
  function automatic logic [31:0] clip_len(input logic [31:0] base, input logic [31:0] len);
    logic [31:0] room;
    room = TOP_LIMIT - base;
    return (len > room) ? room : len;
  endfunction

endpackage

[hdl/ffra_cell.sv]
// one table cell: a free region entry plus the scan token
`timescale 1ns / 1ps
module ffra_cell import ffra_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] cmd_pos,
  input  logic [31:0]   left_base,
  input  logic [31:0]   left_size,
  input  logic          left_tok,
  input  logic [31:0]   right_base,
  input  logic [31:0]   right_size,
  output logic [31:0]   base,
  output logic [31:0]   size,
  output logic          tok,
  output logic [31:0]   rd_base,
  output logic [31:0]   rd_size
);

  logic [31:0] base_r, base_nxt, size_r, size_nxt;
  logic        tok_r, tok_nxt;
  logic        here, above;

  assign here  = (cmd_pos == IW'(IDX));
  assign above = (IW'(IDX) > cmd_pos);

  always_comb begin
    base_nxt = base_r;
    size_nxt = size_r;
    case (cmd.op)
      OP_WRITE: begin
        if (here) begin
          base_nxt = cmd.wbase;
          size_nxt = cmd.wsize;
        end
      end
      OP_SHIFT_DN: begin
        if (here || above) begin
          base_nxt = right_base;
          size_nxt = right_size;
        end
      end
      OP_SHIFT_UP: begin
        if (above) begin
          base_nxt = left_base;
          size_nxt = left_size;
        end else if (here) begin
          base_nxt = cmd.wbase;
          size_nxt = cmd.wsize;
        end
      end
      default: begin
      end
    endcase
    if (cmd.tok_load) tok_nxt = (IDX == 0);
    else if (cmd.tok_adv) tok_nxt = left_tok;
    else tok_nxt = tok_r;
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    size_r <= size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tok_r <= 1'b0;
    else tok_r <= tok_nxt;
  end

  assign base    = base_r;
  assign size    = size_r;
  assign tok     = tok_r;
  assign rd_base = tok_r ? base_r : 32'd0;
  assign rd_size = tok_r ? size_r : 32'd0;

endmodule

[hdl/ffra_ctrl.sv]
// sequencer: config registers, counters and the per-item command stream
`timescale 1ns / 1ps
module ffra_ctrl import ffra_pkg::*; #(
  parameter int MAX = MAX_REGIONS_DEF,
  parameter int IW  = $clog2(MAX),
  parameter int CW  = $clog2(MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  in_item_t      in_item,
  output logic          busy,
  output logic          out_valid,
  output out_item_t     out_result,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic [31:0]   rd_base,
  input  logic [31:0]   rd_size,
  output cell_cmd_t     cmd,
  output logic [IW-1:0] cmd_pos,
  output logic [CW-1:0] used
);

  state_t      state_r, state_nxt;
  logic [31:0] pool_start_r, pool_bytes_r, min_block_r;
  logic [CW-1:0] used_r, used_nxt, idx_r, idx_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] need_r, need_nxt, fbase_r, fbase_nxt, fend_r, fend_nxt;
  logic [31:0] prev_base_r, prev_base_nxt, prev_size_r, prev_size_nxt;
  logic [31:0] prev_end_r, prev_end_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   res_r, res_nxt;
  logic        emit;
  logic [31:0] e_grant;
  logic [1:0]  e_status;
  logic [31:0] pool_len, rounded, flen;
  logic        cur_ok;

  assign pool_len = clip_len(pool_start_r, pool_bytes_r);
  assign rounded  = (in_item.byte_count + ROUND_ADD) & ROUND_MASK;
  assign flen     = clip_len(in_item.region_base, in_item.byte_count);
  assign cur_ok   = (idx_r < used_r);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    need_nxt      = need_r;
    fbase_nxt     = fbase_r;
    fend_nxt      = fend_r;
    prev_base_nxt = prev_base_r;
    prev_size_nxt = prev_size_r;
    prev_end_nxt  = prev_end_r;
    cmd           = '{op: OP_HOLD, wbase: 32'd0, wsize: 32'd0, tok_load: 1'b0, tok_adv: 1'b0};
    cmd_pos       = idx_r[IW-1:0];
    emit          = 1'b0;
    e_grant       = 32'd0;
    e_status      = STAT_DONE;
    case (state_r)
      ST_INIT: begin
        cmd.op    = OP_WRITE;
        cmd_pos   = '0;
        cmd.wbase = pool_start_r;
        cmd.wsize = pool_len;
        used_nxt  = (pool_len != 32'd0) ? CW'(1) : CW'(0);
        sum_nxt   = pool_len;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (in_item.kind)
            KIND_ALLOC: begin
              if (in_item.byte_count > ROUND_MAX) begin
                emit     = 1'b1;
                e_status = STAT_OOM;
              end else begin
                need_nxt     = (rounded < min_block_r) ? min_block_r : rounded;
                idx_nxt      = '0;
                cmd.tok_load = 1'b1;
                state_nxt    = ST_ASCAN;
              end
            end
            KIND_FREE: begin
              if (flen == 32'd0) begin
                emit = 1'b1;
              end else begin
                fbase_nxt    = in_item.region_base;
                need_nxt     = flen;
                fend_nxt     = in_item.region_base + flen;
                idx_nxt      = '0;
                cmd.tok_load = 1'b1;
                state_nxt    = ST_FSCAN;
              end
            end
            KIND_REINIT: begin
              cmd.op    = OP_WRITE;
              cmd_pos   = '0;
              cmd.wbase = pool_start_r;
              cmd.wsize = pool_len;
              used_nxt  = (pool_len != 32'd0) ? CW'(1) : CW'(0);
              sum_nxt   = pool_len;
              emit      = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_ASCAN: begin
        if (!cur_ok) begin
          emit      = 1'b1;
          e_status  = STAT_OOM;
          state_nxt = ST_IDLE;
        end else if (rd_size >= need_r) begin
          e_grant = rd_base;
          if (rd_size == need_r) begin
            cmd.op   = OP_SHIFT_DN;
            used_nxt = used_r - CW'(1);
          end else begin
            cmd.op    = OP_WRITE;
            cmd.wbase = rd_base + need_r;
            cmd.wsize = rd_size - need_r;
          end
          sum_nxt   = sum_r - need_r;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt     = idx_r + CW'(1);
          cmd.tok_adv = 1'b1;
        end
      end
      ST_FSCAN: begin
        if (cur_ok && (rd_base < fbase_r)) begin
          prev_base_nxt = rd_base;
          prev_size_nxt = rd_size;
          prev_end_nxt  = rd_base + rd_size;
          idx_nxt       = idx_r + CW'(1);
          cmd.tok_adv   = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
          if ((idx_r != '0) && (prev_end_r == fbase_r)) begin
            // joins the lower neighbour, maybe the upper one too
            sum_nxt   = sum_r + need_r;
            cmd.op    = OP_WRITE;
            cmd_pos   = IW'(idx_r - CW'(1));
            cmd.wbase = prev_base_r;
            if (cur_ok && (fend_r == rd_base)) begin
              cmd.wsize = prev_size_r + need_r + rd_size;
              state_nxt = ST_FDROP;
            end else begin
              cmd.wsize = prev_size_r + need_r;
              emit      = 1'b1;
            end
          end else if (cur_ok && (fend_r == rd_base)) begin
            cmd.op    = OP_WRITE;
            cmd.wbase = fbase_r;
            cmd.wsize = rd_size + need_r;
            sum_nxt   = sum_r + need_r;
            emit      = 1'b1;
          end else if (used_r >= CW'(MAX)) begin
            emit     = 1'b1;
            e_status = STAT_FULL;
          end else begin
            cmd.op    = OP_SHIFT_UP;
            cmd.wbase = fbase_r;
            cmd.wsize = need_r;
            used_nxt  = used_r + CW'(1);
            sum_nxt   = sum_r + need_r;
            emit      = 1'b1;
          end
        end
      end
      ST_FDROP: begin
        cmd.op    = OP_SHIFT_DN;
        used_nxt  = used_r - CW'(1);
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    ov_nxt  = emit;
    res_nxt = res_r;
    if (emit) begin
      res_nxt.grant_address = e_grant;
      res_nxt.status        = e_status;
      res_nxt.free_bytes    = sum_nxt;
      res_nxt.region_count  = 6'(used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      used_r       <= '0;
      sum_r        <= '0;
      idx_r        <= '0;
      ov_r         <= 1'b0;
      pool_start_r <= POOL_START_RST;
      pool_bytes_r <= POOL_BYTES_RST;
      min_block_r  <= MIN_BLOCK_RST;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_START: pool_start_r <= cfg_data;
          CFG_POOL_BYTES: pool_bytes_r <= cfg_data;
          CFG_MIN_BLOCK:  min_block_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    fbase_r     <= fbase_nxt;
    fend_r      <= fend_nxt;
    prev_base_r <= prev_base_nxt;
    prev_size_r <= prev_size_nxt;
    prev_end_r  <= prev_end_nxt;
    res_r       <= res_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = ov_r;
  assign out_result = res_r;
  assign used       = used_r;

endmodule

[hdl/first_fit_region_allocator_top.sv]
// top level of the first-fit region allocator: cell row plus sequencer
`timescale 1ns / 1ps
// first-fit free region allocator with coalescing
// - command channel: an item transfers on a clock edge with start high and busy low
//   kind 0 allocates byte_count (rounded up to 32, at least min_block),
//   kind 1 frees region_base/byte_count, kind 2 restores the pool
// - result channel: out_valid is high for exactly one cycle with out_result;
//   the receiver cannot stall it, so nothing is held back
// - config port: cfg_we writes cfg_data to register cfg_index (0 pool_start,
//   1 pool_bytes, 2 min_block); pool used at next reinit, min_block at next alloc
// - storage: a row of MAX_REGIONS cells, each holding one free region sorted
//   by address; a token walks the row one cell per cycle during a search,
//   and inserts or removals shift all cells above the target position at once
// - reinit, unknown kind, zero-size free or oversize alloc report without a scan;
//   an alloc or a free walks the token along the row and keeps busy high
//   until it reports, so one item is in work at a time
// - reset: the block leaves reset in an init state that loads cell 0 with the pool;
//   busy stays high in that state
module first_fit_region_allocator_top import ffra_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  output logic        out_valid,
  output out_item_t   out_result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  cell_cmd_t     cmd;
  logic [IW-1:0] cmd_pos;
  logic [CW-1:0] used;
  // per-cell contents, token and token-gated read data
  logic [31:0]   c_base [MAX_REGIONS];
  logic [31:0]   c_size [MAX_REGIONS];
  logic          c_tok  [MAX_REGIONS];
  logic [31:0]   g_base [MAX_REGIONS];
  logic [31:0]   g_size [MAX_REGIONS];
  logic [31:0]   rd_base, rd_size;

  // the row of cells; the ends see zeros
  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
    ffra_cell #(.IDX(k), .IW(IW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cmd_pos    (cmd_pos),
      .left_base  ((k == 0) ? 32'd0 : c_base[(k == 0) ? 0 : k - 1]),
      .left_size  ((k == 0) ? 32'd0 : c_size[(k == 0) ? 0 : k - 1]),
      .left_tok   ((k == 0) ? 1'b0  : c_tok[(k == 0) ? 0 : k - 1]),
      .right_base ((k == MAX_REGIONS - 1) ? 32'd0 :
                   c_base[(k == MAX_REGIONS - 1) ? k : k + 1]),
      .right_size ((k == MAX_REGIONS - 1) ? 32'd0 :
                   c_size[(k == MAX_REGIONS - 1) ? k : k + 1]),
      .base       (c_base[k]),
      .size       (c_size[k]),
      .tok        (c_tok[k]),
      .rd_base    (g_base[k]),
      .rd_size    (g_size[k])
    );
  end

  // only the token cell drives nonzero read data, so an or merges the row
  always_comb begin
    rd_base = 32'd0;
    rd_size = 32'd0;
    for (int k = 0; k < MAX_REGIONS; k++) begin
      rd_base = rd_base | g_base[k];
      rd_size = rd_size | g_size[k];
    end
  end

  ffra_ctrl #(.MAX(MAX_REGIONS), .IW(IW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rd_base    (rd_base),
    .rd_size    (rd_size),
    .cmd        (cmd),
    .cmd_pos    (cmd_pos),
    .used       (used)
  );

`include "first_fit_region_allocator_top_defines.svh"

  // an accepted transfer either keeps the block busy or reports at once
  `FFRA_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid)
  // the region count never exceeds the row length
  `FFRA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used <= CW'(MAX_REGIONS))
  // a dropped free is only reported with a full table
  `FFRA_ASSERT_IMP(a_full_drop, clk, rst_n, out_valid && (out_result.status == STAT_FULL),
                   used == CW'(MAX_REGIONS))

endmodule
